/* rtl/ibss_pkg.sv */
// ibss_pkg: shared types and codes for the indexed byte sequence store
// no dependencies; imported by ibss_cell, indexed_byte_sequence_store and the testbench
package ibss_pkg;

    typedef enum logic [3:0] {
        OP_APPEND     = 4'd0,
        OP_PREPEND    = 4'd1,
        OP_INSERT     = 4'd2,
        OP_DROP_FIRST = 4'd3,
        OP_DROP_LAST  = 4'd4,
        OP_DROP_AT    = 4'd5,
        OP_CLEAR      = 4'd6,
        OP_READ       = 4'd7,
        OP_WRITE      = 4'd8,
        OP_FIND_FIRST = 4'd9,
        OP_FIND_LAST  = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EVAL = 1'b1
    } state_t;

    // broadcast control from the command decoder to every cell
    typedef struct packed {
        logic load;
        logic ins;
        logic del;
        logic wr;
    } cell_ctrl_t;

    localparam int OP_W    = 4;
    localparam int IDX_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;

endpackage

/* rtl/indexed_byte_sequence_store.sv */
// Indexed byte sequence store: an ordered list of up to CAPACITY bytes held in a row of
// cells that all shift in parallel, so append, prepend, insert, remove and write take
// effect in the cycle a command is accepted. Each command gives exactly one result
// (count after the command and a status) once the output register is free; read and
// find results come from per-cell match flags captured at acceptance and reduced in the
// evaluate state. The block takes a command in the idle state and loads its result from
// the evaluate state, so it accepts no new command until the last result is loaded, and
// waits longer while a result waits at the output.
// depends on ibss_pkg and ibss_cell
module indexed_byte_sequence_store
    import ibss_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // index[6:0], data[14:7], zero pad
    input  logic [3:0]  s_tuser,   // operation[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // value[7:0], position[14:8], count[21:15], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    op_t               op_reg;
    status_t           status_reg, status_next;

    logic              accept;
    logic              out_load;

    op_t               in_op;
    logic [IDX_W-1:0]  in_index;
    logic [BYTE_W-1:0] in_data;
    logic [POS_W-1:0]  idx_ext;
    logic [POS_W-1:0]  cnt_ext;
    logic              full;

    cell_ctrl_t        ctrl;
    logic [POS_W-1:0]  cell_pos;

    logic [BYTE_W-1:0] cell_data [CAPACITY];
    logic [BYTE_W-1:0] cell_pick [CAPACITY];
    logic              cell_hit  [CAPACITY];

    logic              m_valid_reg;
    logic [BYTE_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]  position_reg, position_next;
    logic [IDX_W-1:0]  count_reg;
    status_t           mstat_reg;

    logic [BYTE_W-1:0] pick_or;
    logic              any_hit;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  last_pos;

    assign in_op    = op_t'(s_tuser[3:0]);
    assign in_index = s_tdata[6:0];
    assign in_data  = s_tdata[14:7];
    assign idx_ext  = POS_W'(in_index);
    assign cnt_ext  = POS_W'(cnt_reg);
    assign full     = (cnt_ext >= CAP_POS);
    assign accept   = s_tvalid && s_tready;

    // state machine
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EVAL: out_load = !m_valid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // command decode
    always_comb begin
        ctrl        = '0;
        ctrl.load   = accept;
        cell_pos    = idx_ext;
        cnt_next    = cnt_reg;
        status_next = STAT_DONE;
        unique case (in_op) inside
            OP_APPEND: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    ctrl.ins = accept;
                    cell_pos = cnt_ext;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            OP_PREPEND: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    ctrl.ins = accept;
                    cell_pos = '0;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else if (cnt_reg == '0) begin
                    ctrl.ins = accept;
                    cell_pos = '0;
                    cnt_next = cnt_reg + CNT_W'(1);
                end else if (idx_ext > cnt_ext) begin
                    status_next = STAT_IGNORED;
                end else begin
                    ctrl.ins = accept;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            OP_DROP_FIRST: begin
                if (cnt_reg == '0) begin
                    status_next = STAT_IGNORED;
                end else begin
                    ctrl.del = accept;
                    cell_pos = '0;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            OP_DROP_LAST: begin
                if (cnt_reg == '0) begin
                    status_next = STAT_IGNORED;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            OP_DROP_AT: begin
                if (idx_ext >= cnt_ext) begin
                    status_next = STAT_IGNORED;
                end else begin
                    ctrl.del = accept;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            OP_CLEAR: cnt_next = '0;
            OP_READ: begin
                if (idx_ext >= cnt_ext) status_next = STAT_IGNORED;
            end
            OP_WRITE: begin
                if (idx_ext >= cnt_ext) begin
                    status_next = STAT_IGNORED;
                end else begin
                    ctrl.wr = accept;
                end
            end
            OP_FIND_FIRST, OP_FIND_LAST: status_next = STAT_DONE;
            default: status_next = STAT_IGNORED;
        endcase
    end

    // cell chain
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [BYTE_W-1:0] left_d, right_d;
        if (k == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_left
            assign left_d = cell_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_right
            assign right_d = cell_data[k+1];
        end
        ibss_cell #(
            .POS_W    (POS_W),
            .CELL_IDX (k)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pos        (cell_pos),
            .wbyte      (in_data),
            .key        (in_data),
            .sel_idx    (idx_ext),
            .cnt        (cnt_ext),
            .left_data  (left_d),
            .right_data (right_d),
            .data_out   (cell_data[k]),
            .hit_out    (cell_hit[k]),
            .pick_out   (cell_pick[k])
        );
    end

    // reduce captured cell flags
    always_comb begin
        pick_or   = '0;
        any_hit   = 1'b0;
        first_pos = '0;
        last_pos  = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            pick_or = pick_or | cell_pick[k];
            if (cell_hit[k]) first_pos = POS_W'(k);
        end
        for (int k = 0; k < CAPACITY; k++) begin
            any_hit = any_hit | cell_hit[k];
            if (cell_hit[k]) last_pos = POS_W'(k);
        end
    end

    always_comb begin
        value_next    = '0;
        position_next = '1;
        case (op_reg)
            OP_READ: begin
                if (status_reg == STAT_DONE) value_next = pick_or;
            end
            OP_FIND_FIRST: begin
                if (any_hit) position_next = first_pos[IDX_W-1:0];
            end
            OP_FIND_LAST: begin
                if (any_hit) position_next = last_pos[IDX_W-1:0];
            end
            default: begin
                value_next    = '0;
                position_next = '1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) cnt_reg <= cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= in_op;
            status_reg <= status_next;
        end
        if (out_load) begin
            value_reg    <= value_next;
            position_reg <= position_next;
            count_reg    <= IDX_W'(cnt_reg);
            mstat_reg    <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, count_reg, position_reg, value_reg};
    assign m_tuser  = mstat_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_ext <= CAP_POS)
        else $error("element count above capacity");

    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_EVAL)
        else $error("accepted command not evaluated");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && status_reg == STAT_FULL |-> cnt_ext == CAP_POS)
        else $error("full status with room left");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("result lost");
`endif

endmodule

/* rtl/ibss_cell.sv */
// ibss_cell: one storage cell of the sequence chain, holds one byte
// shifts with its neighbors on insert and remove, flags matches for search
// depends on ibss_pkg
module ibss_cell
    import ibss_pkg::*;
#(
    parameter int POS_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [POS_W-1:0]  pos,
    input  logic [BYTE_W-1:0] wbyte,
    input  logic [BYTE_W-1:0] key,
    input  logic [POS_W-1:0]  sel_idx,
    input  logic [POS_W-1:0]  cnt,
    input  logic [BYTE_W-1:0] left_data,
    input  logic [BYTE_W-1:0] right_data,
    output logic [BYTE_W-1:0] data_out,
    output logic              hit_out,
    output logic [BYTE_W-1:0] pick_out
);

    localparam logic [POS_W-1:0] KPOS = POS_W'(CELL_IDX);

    logic [BYTE_W-1:0] data_reg, data_next;
    logic              hit_reg, hit_next;
    logic [BYTE_W-1:0] pick_reg, pick_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (KPOS > pos) begin
                data_next = left_data;
            end else if (KPOS == pos) begin
                data_next = wbyte;
            end
        end else if (ctrl.del) begin
            if (KPOS >= pos) begin
                data_next = right_data;
            end
        end else if (ctrl.wr) begin
            if (KPOS == pos) begin
                data_next = wbyte;
            end
        end
    end

    always_comb begin
        hit_next  = (data_reg == key) && (KPOS < cnt);
        pick_next = (KPOS == sel_idx) ? data_reg : '0;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (ctrl.load) begin
            hit_reg  <= hit_next;
            pick_reg <= pick_next;
        end
    end

    assign data_out = data_reg;
    assign hit_out  = hit_reg;
    assign pick_out = pick_reg;

endmodule

/* verif/indexed_byte_sequence_store_tb.sv */
`timescale 1ns / 100ps
// indexed_byte_sequence_store_tb: self-checking bench for the byte sequence store
// directed and random commands go in over the stream ports; each result is checked
// against a behavioral model of the list. depends on ibss_pkg and the store RTL
module indexed_byte_sequence_store_tb;
    import ibss_pkg::*;

    localparam int DEPTH          = 64;
    localparam int GAP_MAX        = 19;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_LEN      = 50;
    localparam int NUM_PHASES     = 8;
    localparam int TAIL_CYCLES    = 10;
    localparam int OP_CODE_MAX    = 15;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_CHURN
    } mix_t;

    typedef struct {
        logic [3:0] op;
        logic [6:0] idx;
        logic [7:0] data;
        int         gap;
        bit         drain;
    } command_t;

    typedef struct packed {
        logic [7:0] value;
        logic [6:0] position;
        logic [6:0] count;
        logic [1:0] status;
    } response_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // index[6:0], data[14:7], zero pad
    logic [3:0]  s_tuser  = '0;   // operation[3:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // value[7:0], position[14:8], count[21:15], zero pad
    logic [1:0]  m_tuser;         // status[1:0]

    command_t   pending_cmds[$];
    response_t  expected_resp[$];
    command_t   cur_cmd;
    response_t  acc_resp;
    response_t  want;
    logic [7:0] list_bytes [DEPTH];
    int         list_len = 0;
    int         errors = 0;
    int         n_total = 0;
    int         n_cmds = 0;
    int         n_resp = 0;
    int         n_full = 0;
    int         n_ignored = 0;
    int         n_found = 0;
    int         peak_len = 0;
    int         idle_cycles = 0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         rx_mode_left = 0;
    bit         rx_busy = 1'b0;

    indexed_byte_sequence_store #(
        .CAPACITY (DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void remove_entry(int pos);
        int k;
        for (k = pos; k + 1 < list_len; k++) list_bytes[k] = list_bytes[k + 1];
        list_len--;
    endfunction

    // list model: applies one command and returns its result
    function automatic response_t apply_command(logic [3:0] op, logic [6:0] idx,
                                                logic [7:0] data);
        response_t r;
        int        k;
        int        pos;
        r.value    = '0;
        r.position = '1;
        r.status   = STAT_DONE;
        case (op) inside
            OP_APPEND, OP_PREPEND, OP_INSERT: begin
                if (list_len >= DEPTH) begin
                    r.status = STAT_FULL;
                end else if (op == OP_INSERT && list_len != 0 && int'(idx) > list_len) begin
                    r.status = STAT_IGNORED;
                end else begin
                    if (op == OP_APPEND) pos = list_len;
                    else if (op == OP_PREPEND || list_len == 0) pos = 0;
                    else pos = int'(idx);
                    for (k = list_len; k > pos; k--) list_bytes[k] = list_bytes[k - 1];
                    list_bytes[pos] = data;
                    list_len++;
                end
            end
            OP_DROP_FIRST: begin
                if (list_len == 0) r.status = STAT_IGNORED;
                else remove_entry(0);
            end
            OP_DROP_LAST: begin
                if (list_len == 0) r.status = STAT_IGNORED;
                else list_len--;
            end
            OP_DROP_AT: begin
                if (int'(idx) >= list_len) r.status = STAT_IGNORED;
                else remove_entry(int'(idx));
            end
            OP_CLEAR: list_len = 0;
            OP_READ: begin
                if (int'(idx) >= list_len) r.status = STAT_IGNORED;
                else r.value = list_bytes[idx];
            end
            OP_WRITE: begin
                if (int'(idx) >= list_len) r.status = STAT_IGNORED;
                else list_bytes[idx] = data;
            end
            OP_FIND_FIRST: begin
                for (k = list_len - 1; k >= 0; k--)
                    if (list_bytes[k] == data) r.position = k[6:0];
            end
            OP_FIND_LAST: begin
                for (k = 0; k < list_len; k++)
                    if (list_bytes[k] == data) r.position = k[6:0];
            end
            default: r.status = STAT_IGNORED;
        endcase
        r.count = list_len[6:0];
        return r;
    endfunction

    function automatic command_t make_cmd(int op, int idx, int data, int gap, bit drain);
        command_t c;
        c.op    = op[3:0];
        c.idx   = idx[6:0];
        c.data  = data[7:0];
        c.gap   = gap;
        c.drain = drain;
        return c;
    endfunction

    function automatic void add_cmd(command_t c);
        pending_cmds = {pending_cmds, c};
    endfunction

    function automatic int pick_op(mix_t mix);
        int r;
        int op;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 30) op = OP_APPEND;
                else if (r < 55) op = OP_PREPEND;
                else if (r < 80) op = OP_INSERT;
                else if (r < 90) op = $urandom_range(OP_READ, OP_FIND_LAST);
                else if (r < 96) op = $urandom_range(OP_DROP_FIRST, OP_DROP_AT);
                else op = $urandom_range(0, OP_CODE_MAX);
            end
            MIX_DRAIN: begin
                if (r < 65) op = $urandom_range(OP_DROP_FIRST, OP_DROP_AT);
                else if (r < 75) op = $urandom_range(OP_APPEND, OP_INSERT);
                else if (r < 93) op = $urandom_range(OP_READ, OP_FIND_LAST);
                else if (r < 95) op = OP_CLEAR;
                else op = $urandom_range(0, OP_CODE_MAX);
            end
            default: begin
                if (r < 4) begin
                    op = $urandom_range(OP_FIND_LAST + 1, OP_CODE_MAX);
                end else if (r < 6) begin
                    op = OP_CLEAR;
                end else begin
                    op = $urandom_range(OP_APPEND, OP_FIND_LAST - 1);
                    if (op >= OP_CLEAR) op++;
                end
            end
        endcase
        return op;
    endfunction

    // driver: one command per handshake, random gaps between commands
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                acc_resp = apply_command(cur_cmd.op, cur_cmd.idx, cur_cmd.data);
                expected_resp = {expected_resp, acc_resp};
                n_cmds++;
                if (acc_resp.status == STAT_FULL) n_full++;
                if (acc_resp.status == STAT_IGNORED) n_ignored++;
                if (acc_resp.position != '1) n_found++;
                if (list_len > peak_len) peak_len = list_len;
                gap_left = cur_cmd.gap;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0
                         && !(pending_cmds[0].drain && expected_resp.size() != 0)) begin
                cur_cmd = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_cmd.op;
                s_tdata  <= {1'b0, cur_cmd.data, cur_cmd.idx};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transaction, stalls the result side at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            rx_mode_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_resp.size() == 0) begin
                    $error("unexpected result: tdata=%h tuser=%h", m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = expected_resp.pop_front();
                    n_resp++;
                    if (m_tdata[7:0] !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[14:8] !== want.position) begin
                        $error("position: expected %0d, got %0d",
                               $signed(want.position), $signed(m_tdata[14:8]));
                        errors++;
                    end
                    if (m_tdata[21:15] !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, m_tdata[21:15]);
                        errors++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        errors++;
                    end
                end
                if (rx_mode_left == 0) begin
                    rx_busy = $urandom_range(0, 2) != 0;
                    rx_mode_left = $urandom_range(10, 40);
                end
                rx_mode_left--;
                stall_left = rx_busy ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("indexed_byte_sequence_store_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int       p;
        int       i;
        int       op;
        int       idx;
        int       data;
        mix_t     mix;
        bit       few_values;
        bit       busy;
        // empty store corner cases
        add_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 1'b0));
        add_cmd(make_cmd(OP_DROP_FIRST, 0, 0, 1, 1'b0));
        add_cmd(make_cmd(OP_DROP_LAST, 0, 0, 0, 1'b0));
        add_cmd(make_cmd(OP_DROP_AT, 0, 0, 2, 1'b0));
        add_cmd(make_cmd(OP_READ, 0, 0, 0, 1'b0));
        add_cmd(make_cmd(OP_WRITE, 0, 8'h3C, 0, 1'b0));
        add_cmd(make_cmd(OP_FIND_FIRST, 0, 0, 3, 1'b0));
        // insert into empty store ignores the index
        add_cmd(make_cmd(OP_INSERT, 127, 8'h11, 0, 1'b0));
        add_cmd(make_cmd(OP_APPEND, 0, 8'hFF, 0, 1'b0));
        add_cmd(make_cmd(OP_PREPEND, 0, 8'h00, 1, 1'b0));
        add_cmd(make_cmd(OP_INSERT, 1, 8'hAA, 0, 1'b0));
        add_cmd(make_cmd(OP_INSERT, 4, 8'h55, 0, 1'b0));
        add_cmd(make_cmd(OP_INSERT, 6, 8'h66, 0, 1'b0));
        add_cmd(make_cmd(OP_APPEND, 0, 8'hAA, 2, 1'b0));
        add_cmd(make_cmd(OP_FIND_FIRST, 0, 8'hAA, 0, 1'b0));
        add_cmd(make_cmd(OP_FIND_LAST, 0, 8'hAA, 0, 1'b0));
        add_cmd(make_cmd(OP_FIND_LAST, 0, 8'h77, 0, 1'b0));
        add_cmd(make_cmd(OP_READ, 3, 0, 0, 1'b0));
        add_cmd(make_cmd(OP_READ, 6, 0, 1, 1'b0));
        add_cmd(make_cmd(OP_WRITE, 2, 8'h5A, 0, 1'b0));
        add_cmd(make_cmd(OP_DROP_AT, 1, 0, 0, 1'b0));
        add_cmd(make_cmd(OP_DROP_AT, 127, 0, 0, 1'b0));
        add_cmd(make_cmd(OP_DROP_FIRST, 0, 0, 0, 1'b0));
        add_cmd(make_cmd(OP_DROP_LAST, 0, 0, 0, 1'b0));
        add_cmd(make_cmd(OP_FIND_LAST + 1, 0, 0, 0, 1'b0));
        add_cmd(make_cmd(OP_CODE_MAX, 127, 8'hFF, 0, 1'b0));
        add_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 1'b0));

        // random phases: fill toward full, churn, drain toward empty, then random mixes
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) mix = MIX_FILL;
            else if (p == 4 || p == 5) mix = MIX_DRAIN;
            else if (p == 3) mix = MIX_CHURN;
            else mix = mix_t'($urandom_range(MIX_FILL, MIX_CHURN));
            few_values = $urandom_range(0, 1);
            busy = $urandom_range(0, 2) != 0;
            for (i = 0; i < PHASE_LEN; i++) begin
                op = pick_op(mix);
                if ($urandom_range(0, 9) == 0) idx = $urandom_range(DEPTH + 1, 127);
                else idx = $urandom_range(0, DEPTH);
                if (few_values) data = $urandom_range(0, 3) * 8'h55;
                else data = $urandom_range(0, 255);
                add_cmd(make_cmd(op, idx, data,
                                 busy ? $urandom_range(0, GAP_MAX) : 0,
                                 i == 0 && (p == 0 || p == 4)));
            end
        end
        n_total = pending_cmds.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || n_resp < n_total) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("ran %0d commands, %0d results checked, peak length %0d",
                 n_cmds, n_resp, peak_len);
        $display("full-store refusals %0d, ignored commands %0d, find hits %0d",
                 n_full, n_ignored, n_found);
        if (errors == 0) begin
            $display("indexed_byte_sequence_store_tb: PASS");
        end else begin
            $display("indexed_byte_sequence_store_tb: FAIL");
        end
        $finish;
    end

endmodule
